// ----- hdl/swr_pkg.sv -----
`timescale 1ns / 1ps
package swr_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned AMT_W     = 31;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned ST_W      = 2;
  localparam int unsigned FILL_W    = 8;
  localparam int unsigned DEPTH_DEF = 128;

  typedef logic [WORD_W-1:0] word_t;

  localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
  localparam logic [OP_W-1:0] OP_POP     = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK    = 3'd2;
  localparam logic [OP_W-1:0] OP_ROT_B2T = 3'd3;
  localparam logic [OP_W-1:0] OP_ROT_T2B = 3'd4;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;

  localparam word_t WORD_FAIL = '1;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_DOWN,
    CELL_UP
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e mode;
    logic       wrap_en;
  } cell_ctrl_t;

endpackage

// ----- hdl/swr_cell.sv -----
`timescale 1ns / 1ps
module swr_cell #(
  parameter int unsigned CW  = 8,
  parameter int unsigned IDX = 0
) (
  input  logic               clk_i,
  input  swr_pkg::cell_ctrl_t ctrl_i,
  input  logic [CW-1:0]      last_i,
  input  swr_pkg::word_t     left_i,
  input  swr_pkg::word_t     right_i,
  input  swr_pkg::word_t     wrap_i,
  output swr_pkg::word_t     word_o
);
  import swr_pkg::*;

  word_t word_q, word_d;

  always_comb begin
    word_d = word_q;
    unique case (ctrl_i.mode)
      CELL_DOWN: word_d = left_i;
      CELL_UP: begin
        if (ctrl_i.wrap_en && (last_i == CW'(IDX))) begin
          word_d = wrap_i;
        end else begin
          word_d = right_i;
        end
      end
      default: word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

// ----- hdl/swr_mod.sv -----
`timescale 1ns / 1ps
module swr_mod #(
  parameter int unsigned CW = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [swr_pkg::AMT_W-1:0] dividend_i,
  input  logic [CW-1:0]             divisor_i,
  output logic                      done_o,
  output logic [CW-1:0]             rem_o
);
  import swr_pkg::*;

  localparam int unsigned BW = $clog2(AMT_W);

  logic             run_q, done_q;
  logic [BW-1:0]    cnt_q;
  logic [AMT_W-1:0] a_q;
  logic [CW-1:0]    r_q, r_d, div_q;
  logic [CW:0]      trial;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    trial = {r_q, a_q[AMT_W-1]};
    if (trial >= {1'b0, div_q}) begin
      r_d = CW'(trial - {1'b0, div_q});
    end else begin
      r_d = trial[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      a_q    <= '0;
      r_q    <= '0;
      div_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= BW'(AMT_W - 1);
        a_q   <= dividend_i;
        r_q   <= '0;
        div_q <= divisor_i;
      end else if (run_q) begin
        r_q <= r_d;
        a_q <= {a_q[AMT_W-2:0], 1'b0};
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = r_q;

endmodule

// ----- hdl/stack_with_rotation_core.sv -----
`timescale 1ns / 1ps
// Push, pop, failed peek, rotation of an empty stack, unused op: result in the cycle
// after the transfer, one op per cycle. Peek: the cell ring makes one full turn.
// Rotations: the divider reduces amount mod count one dividend bit at a time, the core
// acts on the remainder, and the ring steps, up to count-1 steps, before the result.
// The result strobe done_o is high for one cycle; the receiver cannot stall.
// rst_ni (async, active low) empties the stack; cell contents are not cleared.
module stack_with_rotation_core #(
  parameter int unsigned DEPTH = swr_pkg::DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic        [swr_pkg::OP_W-1:0]   op_i,
  input  logic signed [swr_pkg::WORD_W-1:0] value_i,
  input  logic        [swr_pkg::AMT_W-1:0]  amount_i,
  output logic                              done_o,
  output logic signed [swr_pkg::WORD_W-1:0] data_o,
  output logic        [swr_pkg::ST_W-1:0]   status_o,
  output logic        [swr_pkg::FILL_W-1:0] fill_o
);
  import swr_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_ROT
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   count_q, rem_q, tgt_q;
  logic            peek_q, b2t_q, done_q;
  word_t           data_q;
  logic [ST_W-1:0] status_q;

  word_t         cell_w [DEPTH];
  cell_ctrl_t    ctrl;
  logic [CW-1:0] last_idx;
  logic          accept, full, empty, peek_ok;
  logic          mod_start, mod_done;
  logic [CW-1:0] mod_rem;

  assign accept    = start_i && (state_q == S_IDLE);
  assign full      = (count_q == CW'(DEPTH));
  assign empty     = (count_q == '0);
  assign peek_ok   = (amount_i < AMT_W'(count_q));
  assign last_idx  = count_q - 1'b1;
  assign mod_start = accept && !empty && ((op_i == OP_ROT_B2T) || (op_i == OP_ROT_T2B));

  always_comb begin
    ctrl.mode    = CELL_HOLD;
    ctrl.wrap_en = 1'b0;
    if (state_q == S_ROT) begin
      ctrl.mode    = CELL_UP;
      ctrl.wrap_en = 1'b1;
    end else if (accept) begin
      if ((op_i == OP_PUSH) && !full) begin
        ctrl.mode = CELL_DOWN;
      end else if ((op_i == OP_POP) && !empty) begin
        ctrl.mode = CELL_UP;
      end
    end
  end

  // cell 0 is the top of the stack
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = value_i;
    end else begin : g_mid_l
      assign left_w = cell_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = cell_w[0];
    end else begin : g_mid_r
      assign right_w = cell_w[i+1];
    end
    swr_cell #(
      .CW (CW),
      .IDX(i)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .last_i (last_idx),
      .left_i (left_w),
      .right_i(right_w),
      .wrap_i (cell_w[0]),
      .word_o (cell_w[i])
    );
  end

  swr_mod #(
    .CW(CW)
  ) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mod_start),
    .dividend_i(amount_i),
    .divisor_i (count_q),
    .done_o    (mod_done),
    .rem_o     (mod_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      rem_q    <= '0;
      tgt_q    <= '0;
      peek_q   <= 1'b0;
      b2t_q    <= 1'b0;
      done_q   <= 1'b0;
      data_q   <= '0;
      status_q <= ST_OK;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            data_q   <= '0;
            status_q <= ST_OK;
            case (op_i) inside
              OP_PUSH: begin
                done_q <= 1'b1;
                if (full) begin
                  status_q <= ST_OVERFLOW;
                end else begin
                  count_q <= count_q + 1'b1;
                end
              end
              OP_POP: begin
                done_q <= 1'b1;
                if (empty) begin
                  data_q   <= WORD_FAIL;
                  status_q <= ST_EMPTY;
                end else begin
                  data_q  <= cell_w[0];
                  count_q <= count_q - 1'b1;
                end
              end
              OP_PEEK: begin
                if (!peek_ok) begin
                  done_q   <= 1'b1;
                  data_q   <= WORD_FAIL;
                  status_q <= ST_EMPTY;
                end else begin
                  peek_q  <= 1'b1;
                  rem_q   <= count_q;
                  tgt_q   <= count_q - CW'(amount_i);
                  state_q <= S_ROT;
                end
              end
              OP_ROT_B2T, OP_ROT_T2B: begin
                if (empty) begin
                  done_q <= 1'b1;
                end else begin
                  peek_q  <= 1'b0;
                  b2t_q   <= (op_i == OP_ROT_B2T);
                  state_q <= S_DIV;
                end
              end
              default: done_q <= 1'b1;
            endcase
          end
        end
        S_DIV: begin
          if (mod_done) begin
            if (mod_rem == '0) begin
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              rem_q   <= b2t_q ? (count_q - mod_rem) : mod_rem;
              state_q <= S_ROT;
            end
          end
        end
        S_ROT: begin
          if (peek_q && (rem_q == tgt_q)) begin
            data_q <= cell_w[0];
          end
          rem_q <= rem_q - 1'b1;
          if (rem_q == CW'(1)) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign data_o   = data_q;
  assign status_o = status_q;
  assign fill_o   = FILL_W'(count_q);

endmodule

// ----- hdl/swr_chk.sv -----
`timescale 1ns / 1ps
module swr_chk #(
  parameter int unsigned DEPTH = swr_pkg::DEPTH_DEF
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start_i,
  input logic                              busy_o,
  input logic        [swr_pkg::OP_W-1:0]   op_i,
  input logic signed [swr_pkg::WORD_W-1:0] value_i,
  input logic        [swr_pkg::AMT_W-1:0]  amount_i,
  input logic                              done_o,
  input logic signed [swr_pkg::WORD_W-1:0] data_o,
  input logic        [swr_pkg::ST_W-1:0]   status_o,
  input logic        [swr_pkg::FILL_W-1:0] fill_o
);
  import swr_pkg::*;

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy rose without a transfer");

  a_done_when_busy_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("busy ended without a result");

  a_push_pop_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && ((op_i == OP_PUSH) || (op_i == OP_POP)) |=> done_o && !busy_o)
    else $error("push or pop result missing");

  a_fail_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_EMPTY) |-> (data_o == WORD_FAIL))
    else $error("failed read must return all ones");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_OVERFLOW) |-> (fill_o == FILL_W'(DEPTH)) && (data_o == '0))
    else $error("overflow reported while not full");

endmodule

bind stack_with_rotation_core swr_chk #(.DEPTH(DEPTH)) u_swr_chk (.*);
